@@ rtl/core/qrg_pkg.sv @@
// Shared types and constants for the quantized ramp generator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package qrg_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_LOW_LEVEL     = 3'd0;
  localparam logic [2:0] REG_HIGH_LEVEL    = 3'd1;
  localparam logic [2:0] REG_RISING        = 3'd2;
  localparam logic [2:0] REG_LEVEL_STEP    = 3'd3;
  localparam logic [2:0] REG_HOLD_COUNT    = 3'd4;
  localparam logic [2:0] REG_LEVEL_QUANTUM = 3'd5;

  // Q8.24 level limits
  localparam logic signed [31:0] LEVEL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] LEVEL_MIN = 32'sh8000_0000;

  // Input word
  typedef struct packed {
    logic func;
    logic reload_level;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] level;
    logic               done_res;
  } out_word_t;

  // Configuration register set
  typedef struct packed {
    logic signed [31:0] low_level;
    logic signed [31:0] high_level;
    logic               rising;
    logic [30:0]        level_step;
    logic [15:0]        hold_count;
    logic [30:0]        level_quantum;
  } cfg_t;

  // Remainder unit handshake
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [30:0] rem;
  } div_rsp_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_POST
  } seq_state_t;

endpackage

`default_nettype wire

@@ rtl/core/qrg_regs.sv @@
// APB-style configuration registers of the quantized ramp generator.
// Depends on qrg_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module qrg_regs
  import qrg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t        cfg_r;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Write the addressed register; ignore addresses past the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_level     <= '0;
      cfg_r.high_level    <= '0;
      cfg_r.rising        <= 1'b1;
      cfg_r.level_step    <= '0;
      cfg_r.hold_count    <= '0;
      cfg_r.level_quantum <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_LOW_LEVEL:     cfg_r.low_level     <= pwdata;
        REG_HIGH_LEVEL:    cfg_r.high_level    <= pwdata;
        REG_RISING:        cfg_r.rising        <= pwdata[0];
        REG_LEVEL_STEP:    cfg_r.level_step    <= pwdata[30:0];
        REG_HOLD_COUNT:    cfg_r.hold_count    <= pwdata[15:0];
        REG_LEVEL_QUANTUM: cfg_r.level_quantum <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_LOW_LEVEL:     prdata = cfg_r.low_level;
      REG_HIGH_LEVEL:    prdata = cfg_r.high_level;
      REG_RISING:        prdata = {31'd0, cfg_r.rising};
      REG_LEVEL_STEP:    prdata = {1'b0, cfg_r.level_step};
      REG_HOLD_COUNT:    prdata = {16'd0, cfg_r.hold_count};
      REG_LEVEL_QUANTUM: prdata = {1'b0, cfg_r.level_quantum};
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/qrg_div.sv @@
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on qrg_pkg for the div_req_t and div_rsp_t structs.
`default_nettype none

module qrg_div
  import qrg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [30:0] dvs_r, dvs_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [31:0] rem_sh;
  logic [31:0] rem_sub;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign rem_sh  = {rem_r, dvd_r[31]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[30:0], 1'b0};
      // remainder stays below the divisor, so 31 bits hold it
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sub[30:0];
      end else begin
        rem_nxt = rem_sh[30:0];
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  // Done follows the last busy cycle only
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("remainder done without a preceding busy cycle");

  // A finished unit is idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("remainder unit busy while reporting done");

  // Remainder never reaches the divisor while working
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !$past(req.start) && dvs_r != '0) |-> (rem_r < dvs_r))
    else $error("remainder out of range");

endmodule

`default_nettype wire

@@ rtl/core/quantized_ramp_generator_core.sv @@
// Top level of the quantized ramp generator: sequencer, ramp state, output word.
// Depends on qrg_pkg, qrg_regs and qrg_div.
`default_nettype none

// Linear ramp generator with a quantized, held output in Q8.24. Each input word
// is a start (func = 1) or a sample tick (func = 0) and yields one result word.
// A start, a tick after done, a tick that ends the segment, a tick inside a hold
// period, a tick that needs no catch-up and a tick with zero quantum all finish
// in the accept cycle, so such words can be taken once per clock while the
// output register is free. A tick whose output must catch up with the ramp by
// whole quanta runs the bit-serial remainder unit, waits in ST_DIV to see it
// finish and forms the level in ST_POST; in_ready is low throughout. A word
// is taken only while the output register is empty or being read in the same
// cycle, so a result that waits for out_ready holds the input off.
module quantized_ramp_generator_core
  import qrg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_word,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  div_req_t   dreq;
  div_rsp_t   drsp;

  seq_state_t         state_r, state_nxt;
  logic signed [31:0] ramp_r, ramp_nxt;
  logic signed [31:0] outl_r, outl_nxt;
  logic [15:0]        hold_r, hold_nxt;
  logic               fin_r, fin_nxt;
  logic               oval_r, oval_nxt;
  out_word_t          oword_r, oword_nxt;

  logic               accept;
  logic               out_free;
  logic               load_out;
  logic               up;
  logic               moving;
  logic signed [32:0] ramp_ext;
  logic signed [32:0] outl_ext;
  logic signed [32:0] ramp_sum;
  logic signed [31:0] ramp_step;
  logic signed [32:0] step_ext;
  logic signed [32:0] cu_ext;
  logic signed [32:0] diff;
  logic               need_cu;
  logic [30:0]        pad;
  logic signed [32:0] fin_sum;
  logic signed [31:0] fin_level;

  qrg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qrg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign up       = cfg.rising;
  assign out_free = !oval_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Step the ramp one increment, saturating at the level limits
  assign ramp_ext = {ramp_r[31], ramp_r};
  assign outl_ext = {outl_r[31], outl_r};
  assign step_ext = {2'b00, cfg.level_step};
  assign moving   = up ? (ramp_r < cfg.high_level) : (ramp_r > cfg.low_level);
  assign ramp_sum = up ? (ramp_ext + step_ext) : (ramp_ext - step_ext);
  assign ramp_step = (ramp_sum[32] != ramp_sum[31]) ? (up ? LEVEL_MAX : LEVEL_MIN)
                                                    : ramp_sum[31:0];

  // Catch-up distance from the output to the stepped ramp
  assign cu_ext  = {ramp_step[31], ramp_step};
  assign need_cu = up ? (outl_r < ramp_step) : (outl_r > ramp_step);
  assign diff    = up ? (cu_ext - outl_ext) : (outl_ext - cu_ext);

  // Land on the ramp plus the unfilled part of the last quantum
  assign pad       = (drsp.rem != '0) ? (cfg.level_quantum - drsp.rem) : '0;
  assign fin_sum   = up ? (ramp_ext + {2'b00, pad}) : (ramp_ext - {2'b00, pad});
  assign fin_level = (fin_sum[32] != fin_sum[31]) ? (up ? LEVEL_MAX : LEVEL_MIN)
                                                  : fin_sum[31:0];

  // Sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    ramp_nxt      = ramp_r;
    outl_nxt      = outl_r;
    hold_nxt      = hold_r;
    fin_nxt       = fin_r;
    load_out      = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = diff[31:0];
    dreq.divisor  = cfg.level_quantum;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          if (in_word.func) begin
            if (in_word.reload_level) begin
              outl_nxt = up ? cfg.low_level : cfg.high_level;
              ramp_nxt = up ? cfg.low_level : cfg.high_level;
            end else begin
              ramp_nxt = outl_r;
            end
            hold_nxt = cfg.hold_count;
            fin_nxt  = 1'b0;
          end else if (!fin_r) begin
            if (moving) begin
              ramp_nxt = ramp_step;
              if (hold_r != '0) begin
                hold_nxt = hold_r - 16'd1;
              end else begin
                hold_nxt = cfg.hold_count;
                if (need_cu) begin
                  if (cfg.level_quantum == '0) begin
                    outl_nxt = ramp_step;
                  end else begin
                    // defer the result until the remainder is known
                    load_out   = 1'b0;
                    dreq.start = 1'b1;
                    state_nxt  = ST_DIV;
                  end
                end
              end
            end else begin
              outl_nxt = up ? cfg.high_level : cfg.low_level;
              fin_nxt  = 1'b1;
            end
          end
        end
      end
      ST_DIV: begin
        if (drsp.done) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (out_free) begin
          outl_nxt  = fin_level;
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register: take a new word when free, drop it once taken
  always_comb begin
    oval_nxt  = oval_r && !out_ready;
    oword_nxt = oword_r;
    if (load_out) begin
      oval_nxt           = 1'b1;
      oword_nxt.level    = outl_nxt;
      oword_nxt.done_res = fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ramp_r  <= '0;
      outl_r  <= '0;
      hold_r  <= '0;
      fin_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ramp_r  <= ramp_nxt;
      outl_r  <= outl_nxt;
      hold_r  <= hold_nxt;
      fin_r   <= fin_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oword_r <= oword_nxt;
  end

  assign out_valid = oval_r;
  assign out_word  = oword_r;

  // No new word while the sequencer is working
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == ST_IDLE))
    else $error("input ready outside idle");

  // The remainder unit runs whenever the sequencer waits on it
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (drsp.busy || drsp.done))
    else $error("sequencer waiting on an idle remainder unit");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("output word overwritten before it was taken");

  // A catch-up result is never marked done
  a_post_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POST) |-> !fin_r)
    else $error("catch-up on a finished segment");

endmodule

`default_nettype wire

@@ verif/quantized_ramp_generator_core_test.sv @@
// Self-checking bench for quantized_ramp_generator_core: random handshakes, APB setup.
// Depends on qrg_pkg and the core RTL; predicts each result word in a small class.
`timescale 1ns / 100ps

// Tracks ramp, held output, hold count and done; queues the level words due out
class level_tracker;
  // Register copies, widened to 64 bits so the arithmetic never wraps
  longint lo_lvl, hi_lvl, step_sz, quantum;
  int     hold_len;
  bit     rise_dir;
  // Generator state
  longint ramp_lvl, out_lvl;
  int     hold_left;
  bit     seg_done;
  qrg_pkg::out_word_t due_levels[$];
  int errors, checked;

  function new();
    lo_lvl = 0; hi_lvl = 0; step_sz = 0; quantum = 0; hold_len = 0; rise_dir = 1'b1;
    ramp_lvl = 0; out_lvl = 0; hold_left = 0; seg_done = 1'b0;
    errors = 0; checked = 0;
  endfunction

  // Mirror a register write; unknown indexes change nothing
  function void set_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      qrg_pkg::REG_LOW_LEVEL:     lo_lvl = $signed(data);
      qrg_pkg::REG_HIGH_LEVEL:    hi_lvl = $signed(data);
      qrg_pkg::REG_RISING:        rise_dir = data[0];
      qrg_pkg::REG_LEVEL_STEP:    step_sz = data[30:0];
      qrg_pkg::REG_HOLD_COUNT:    hold_len = data[15:0];
      qrg_pkg::REG_LEVEL_QUANTUM: quantum = data[30:0];
      default: ;
    endcase
  endfunction

  function longint clip_level(longint v);
    if (v > qrg_pkg::LEVEL_MAX) return qrg_pkg::LEVEL_MAX;
    if (v < qrg_pkg::LEVEL_MIN) return qrg_pkg::LEVEL_MIN;
    return v;
  endfunction

  // Advance on one accepted word and queue its result; returns 0 for a tick after done
  function bit take_word(qrg_pkg::in_word_t w);
    qrg_pkg::out_word_t e;
    longint gap, steps;
    bit acted;
    acted = 1'b1;
    if (w.func) begin
      if (w.reload_level) out_lvl = rise_dir ? lo_lvl : hi_lvl;
      ramp_lvl = out_lvl;
      hold_left = hold_len;
      seg_done = 1'b0;
    end else if (seg_done) begin
      acted = 1'b0;
    end else if (rise_dir ? (ramp_lvl < hi_lvl) : (ramp_lvl > lo_lvl)) begin
      ramp_lvl = clip_level(rise_dir ? ramp_lvl + step_sz : ramp_lvl - step_sz);
      if (hold_left > 0) begin
        hold_left--;
      end else begin
        hold_left = hold_len;
        // Catch up in whole quanta, landing on or just past the ramp
        if (rise_dir ? (out_lvl < ramp_lvl) : (out_lvl > ramp_lvl)) begin
          if (quantum == 0) begin
            out_lvl = ramp_lvl;
          end else begin
            gap = rise_dir ? ramp_lvl - out_lvl : out_lvl - ramp_lvl;
            steps = (gap + quantum - 1) / quantum;
            out_lvl = clip_level(rise_dir ? out_lvl + steps * quantum
                                          : out_lvl - steps * quantum);
          end
        end
      end
    end else begin
      // Ramp at or past its end: pin the output and finish
      out_lvl = rise_dir ? hi_lvl : lo_lvl;
      seg_done = 1'b1;
    end
    e.level = out_lvl[31:0];
    e.done_res = seg_done;
    due_levels.push_back(e);
    return acted;
  endfunction

  task report(string what);
    if (errors < 20) $display("mismatch: %s", what);
    errors++;
  endtask

  // Compare one result word with the oldest queued one
  task match_level(qrg_pkg::out_word_t got);
    qrg_pkg::out_word_t e;
    checked++;
    if (due_levels.size() == 0) begin
      report($sformatf("unexpected word level=%h done=%b", got.level, got.done_res));
    end else begin
      e = due_levels.pop_front();
      if (got.level !== e.level)
        report($sformatf("word %0d level %h, want %h", checked, got.level, e.level));
      if (got.done_res !== e.done_res)
        report($sformatf("word %0d done %b, want %b", checked, got.done_res, e.done_res));
    end
  endtask
endclass

module quantized_ramp_generator_core_test;
  import qrg_pkg::*;

  localparam logic        FN_TICK     = 1'b0;
  localparam logic        FN_START    = 1'b1;
  localparam logic [2:0]  REG_SPARE_A = 3'd6;
  localparam logic [2:0]  REG_SPARE_B = 3'd7;
  localparam longint      FIELD31_MAX = 'h7FFF_FFFF;
  localparam int          RANDOM_WORDS = 850;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  level_tracker board = new();
  bit quiet = 1'b0;
  int active_words = 0;
  int sent_words = 0;
  int idle_ticks = 0;
  int settings = 0;
  int stall_cycles = 0;

  quantized_ramp_generator_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // End the run if nothing moves on any port for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Take result words, stalling at random except in the quiet phase
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.match_level(out_word);
    out_ready <= quiet || ($urandom_range(99) >= 10);
  end

  // Offer one word, idling first at random, and hold it until accepted
  task automatic send_word(input logic func, input logic reload);
    in_word_t w;
    w.func = func;
    w.reload_level = reload;
    if (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 10);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    sent_words++;
    if (board.take_word(w)) active_words++;
    else idle_ticks++;
  endtask

  // Drop valid and wait until every queued word is out and the core is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (board.due_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, data);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(input logic [31:0] lo, input logic [31:0] hi,
                              input logic rise, input logic [31:0] step,
                              input logic [31:0] hold, input logic [31:0] quant);
    drain();
    write_reg(REG_LOW_LEVEL, lo);
    write_reg(REG_HIGH_LEVEL, hi);
    write_reg(REG_RISING, {31'd0, rise});
    write_reg(REG_LEVEL_STEP, step);
    write_reg(REG_HOLD_COUNT, hold);
    write_reg(REG_LEVEL_QUANTUM, quant);
    settings++;
  endtask

  // Pick levels, a step that ends the ramp in about ticks steps, and a hold and quantum
  task automatic random_setting(output int ticks);
    longint a, b, lo, hi, span, stepv, quant;
    logic [15:0] hold;
    logic rise;
    a = longint'($signed($urandom));
    case ($urandom_range(3))
      0: b = longint'($signed($urandom));
      1: b = a + longint'($urandom_range(32'h0000_1000));
      default: b = a + longint'($urandom_range(32'h0800_0000));
    endcase
    if (b > LEVEL_MAX) b = LEVEL_MAX;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    // Now and then swap the ends so the levels are reversed
    if ($urandom_range(7) == 0) begin
      lo = hi;
      hi = (a < b) ? a : b;
    end
    span = hi - lo;
    if (span < 0) span = -span;
    rise = 1'($urandom_range(1));
    ticks = $urandom_range(1, 40);
    case ($urandom_range(15))
      0: stepv = 0;
      1: stepv = FIELD31_MAX;
      default: stepv = span / ticks + 1;
    endcase
    if (stepv > FIELD31_MAX) stepv = FIELD31_MAX;
    case ($urandom_range(7))
      5: hold = 16'd0;
      6: hold = 16'($urandom_range(16'hFFFF));
      7: hold = 16'hFFFF;
      default: hold = 16'($urandom_range(3));
    endcase
    case ($urandom_range(7))
      0, 1: quant = 0;
      5: quant = $urandom_range(1, 255);
      6: quant = $urandom & 32'h7FFF_FFFF;
      7: quant = FIELD31_MAX;
      default: quant = span / int'($urandom_range(1, 12));
    endcase
    if (quant > FIELD31_MAX) quant = FIELD31_MAX;
    load_setting(lo[31:0], hi[31:0], rise, stepv[31:0], {16'd0, hold}, quant[31:0]);
  endtask

  initial begin : stimulus
    int ticks, seg_ticks, phase, phase_start, n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset levels are equal, so the first tick ends the segment at once
    send_word(FN_TICK, 1'b0);

    // Full-range rise, largest step, no quantum: ramp saturates at the top
    load_setting(LEVEL_MIN, LEVEL_MAX, 1'b1, 32'(FIELD31_MAX), 32'd0, 32'd0);
    send_word(FN_START, 1'b1);
    repeat (4) send_word(FN_TICK, 1'b0);
    // Tick after done, with reload set, which a tick ignores
    send_word(FN_TICK, 1'b1);

    // Falling with the largest quantum: the catch-up clamps at the bottom
    load_setting(LEVEL_MIN, 32'h9000_0000, 1'b0, 32'd1, 32'd0, 32'(FIELD31_MAX));
    send_word(FN_START, 1'b1);
    repeat (2) send_word(FN_TICK, 1'b0);
    // Rising near the top: the catch-up clamps at the top
    load_setting(32'h7000_0000, LEVEL_MAX, 1'b1, 32'd1, 32'd0, 32'(FIELD31_MAX));
    send_word(FN_START, 1'b1);
    send_word(FN_TICK, 1'b0);

    // Reversed levels end on the first tick; restart without reload too
    load_setting(32'h1000_0000, 32'hF000_0000, 1'b1, 32'h0100_0000, 32'hFFFF,
                 32'h0080_0000);
    send_word(FN_START, 1'b1);
    repeat (2) send_word(FN_TICK, 1'b0);
    send_word(FN_START, 1'b0);
    send_word(FN_TICK, 1'b0);

    // Longest hold; writes to unused indexes must change nothing
    load_setting(32'h0, 32'h0100_0000, 1'b1, 32'h0010_0000, 32'hFFFF, 32'h0030_0000);
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    send_word(FN_START, 1'b1);
    repeat (3) send_word(FN_TICK, 1'b0);

    // Random phases: mostly whole segments, with cut-short ramps and noise
    active_words = 0;
    sent_words = 0;
    phase = 0;
    while (sent_words < RANDOM_WORDS) begin
      random_setting(ticks);
      quiet = (phase == 4);
      phase_start = sent_words;
      while (sent_words - phase_start < 65 && sent_words < RANDOM_WORDS) begin
        seg_ticks = ($urandom_range(7) == 0) ? $urandom_range(ticks)
                                             : ticks + $urandom_range(3);
        send_word(FN_START, $urandom_range(99) < 85);
        for (n = 0; n < seg_ticks; n++) begin
          if ($urandom_range(19) == 0)
            send_word(1'($urandom_range(1)), 1'($urandom_range(1)));
          else send_word(FN_TICK, 1'($urandom_range(1)));
        end
      end
      phase++;
    end
    quiet = 1'b0;

    drain();
    $display("covered %0d register settings, %0d live words, %0d ticks after done",
             settings, active_words, idle_ticks);
    $display("compared %0d result words, %0d mismatches", board.checked, board.errors);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
